/* sv/wps_pkg.sv */
package wps_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE_HZ     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLE_COUNT = 3'd3;
    localparam int CFG_DATA_W = 36;

    // register reset values
    localparam logic [3:0]  RST_CHANNEL_COUNT      = 4'd2;
    localparam logic [19:0] RST_SAMPLE_RATE_HZ     = 20'd44100;
    localparam logic [5:0]  RST_SAMPLE_BITS        = 6'd16;
    localparam logic [35:0] RST_TOTAL_SAMPLE_COUNT = 36'd0;

    // request kinds on the input side
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // supported sample depths
    localparam logic [5:0] DEPTH_8  = 6'd8;
    localparam logic [5:0] DEPTH_12 = 6'd12;
    localparam logic [5:0] DEPTH_16 = 6'd16;
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_32 = 6'd32;

    // header fields, tags little-endian so byte 0 sits in the low bits
    localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE       = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT        = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA       = 32'h6174_6164;
    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [15:0] PCM_FORMAT     = 16'd1;
    localparam logic [31:0] RIFF_EXTRA     = 32'd36;
    localparam logic [7:0]  OFFSET_BIN     = 8'h80;

    // byte counting
    localparam int IDX_W = 6;
    localparam logic [IDX_W-1:0] HDR_LAST_IDX = 6'd43;

    // queue between front and back
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_SMP,
        KIND_ERR
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] last_idx;
        logic [31:0]      data;
    } desc_t;

    typedef struct packed {
        logic [3:0]  channel_count;
        logic [19:0] sample_rate_hz;
        logic [5:0]  sample_bits;
        logic [35:0] total_sample_count;
    } cfg_t;

endpackage

/* sv/wps_front.sv */
module wps_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [31:0]                  s_tdata,   // [31:0] sample_value
    input  logic                                s_tuser,   // [0] req_type
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                q_full,
    output logic                                q_push,
    output wps_pkg::desc_t                      q_desc,
    output wps_pkg::cfg_t                       cfg
);

    wps_pkg::cfg_t cfg_reg;
    wps_pkg::cfg_t cfg_next;
    logic [31:0]   s_bits;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;
    assign s_bits    = s_tdata;

    // register file write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                wps_pkg::CFG_CHANNEL_COUNT:
                    cfg_next.channel_count = cfg_data[3:0];
                wps_pkg::CFG_SAMPLE_RATE_HZ:
                    cfg_next.sample_rate_hz = cfg_data[19:0];
                wps_pkg::CFG_SAMPLE_BITS:
                    cfg_next.sample_bits = cfg_data[5:0];
                wps_pkg::CFG_TOTAL_SAMPLE_COUNT:
                    cfg_next.total_sample_count = cfg_data[35:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count      <= wps_pkg::RST_CHANNEL_COUNT;
            cfg_reg.sample_rate_hz     <= wps_pkg::RST_SAMPLE_RATE_HZ;
            cfg_reg.sample_bits        <= wps_pkg::RST_SAMPLE_BITS;
            cfg_reg.total_sample_count <= wps_pkg::RST_TOTAL_SAMPLE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify the item and prepare its bytes
    always_comb
    begin
        q_desc.kind     = wps_pkg::KIND_HDR;
        q_desc.last_idx = wps_pkg::HDR_LAST_IDX;
        q_desc.data     = 32'd0;
        if (s_tuser == wps_pkg::REQ_SAMPLE)
        begin
            q_desc.kind = wps_pkg::KIND_SMP;
            case (cfg_reg.sample_bits)
                wps_pkg::DEPTH_8:
                begin
                    q_desc.last_idx = 6'd0;
                    q_desc.data     = {24'd0, s_bits[7:0] ^ wps_pkg::OFFSET_BIN};
                end
                wps_pkg::DEPTH_12:
                begin
                    q_desc.last_idx = 6'd1;
                    q_desc.data     = {16'd0, s_bits[11:0], 4'd0};
                end
                wps_pkg::DEPTH_16:
                begin
                    q_desc.last_idx = 6'd1;
                    q_desc.data     = {16'd0, s_bits[15:0]};
                end
                wps_pkg::DEPTH_24:
                begin
                    q_desc.last_idx = 6'd2;
                    q_desc.data     = {8'd0, s_bits[23:0]};
                end
                wps_pkg::DEPTH_32:
                begin
                    q_desc.last_idx = 6'd3;
                    q_desc.data     = s_bits;
                end
                default:
                begin
                    q_desc.kind     = wps_pkg::KIND_ERR;
                    q_desc.last_idx = 6'd0;
                    q_desc.data     = 32'd0;
                end
            endcase
        end
    end

endmodule

/* sv/wps_queue.sv */
module wps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wps_pkg::desc_t desc_in,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output wps_pkg::desc_t head
);

    wps_pkg::desc_t                 entry_reg [wps_pkg::QUEUE_DEPTH];
    logic [wps_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [wps_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [wps_pkg::QUEUE_AW:0]     count_reg;
    logic [wps_pkg::QUEUE_AW:0]     count_next;
    logic                           do_pop;

    assign full       = (count_reg == (wps_pkg::QUEUE_AW+1)'(wps_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= desc_in;
        end
    end

endmodule

/* sv/wps_back.sv */
module wps_back (
    input  logic           clk,
    input  logic           rst_n,
    input  wps_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  wps_pkg::desc_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [7:0] out_byte
    output logic           m_tlast,   // last_byte
    output logic           m_tuser    // [0] depth_error
);

    logic [9:0]                 cb_reg;
    logic [6:0]                 frame_reg;
    logic [45:0]                prod_reg;
    logic [26:0]                avg_bps_reg;
    logic [31:0]                audio_bytes;
    logic [351:0]               hdr_vec;
    logic [wps_pkg::IDX_W-1:0]  idx_reg;
    logic [wps_pkg::IDX_W-1:0]  idx_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [7:0]                 byte_reg;
    logic [7:0]                 byte_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       err_reg;
    logic                       err_next;
    logic                       emit;
    logic                       at_last;

    // header arithmetic, two registered multiply stages off the config
    always_ff @(posedge clk)
    begin
        cb_reg      <= cfg.channel_count * cfg.sample_bits;
        frame_reg   <= 7'(cfg.sample_bits[5:3] * cfg.channel_count);
        prod_reg    <= cb_reg * cfg.total_sample_count;
        avg_bps_reg <= cfg.sample_rate_hz * frame_reg;
    end

    assign audio_bytes = prod_reg[34:3];

    // header image, byte 0 in the low bits
    assign hdr_vec = {
        audio_bytes,
        wps_pkg::TAG_DATA,
        {10'd0, cfg.sample_bits},
        {9'd0, frame_reg},
        {5'd0, avg_bps_reg},
        {12'd0, cfg.sample_rate_hz},
        {12'd0, cfg.channel_count},
        wps_pkg::PCM_FORMAT,
        wps_pkg::FMT_CHUNK_SIZE,
        wps_pkg::TAG_FMT,
        wps_pkg::TAG_WAVE,
        audio_bytes + wps_pkg::RIFF_EXTRA,
        wps_pkg::TAG_RIFF
    };

    assign emit    = q_valid && (!valid_reg || m_tready);
    assign at_last = (idx_reg == q_head.last_idx);
    assign q_pop   = emit && at_last;

    // byte selection for the item at the queue head
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_tready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            last_next  = at_last;
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
            case (q_head.kind)
                wps_pkg::KIND_HDR:
                begin
                    byte_next = hdr_vec[{idx_reg, 3'b000} +: 8];
                    err_next  = 1'b0;
                end
                wps_pkg::KIND_SMP:
                begin
                    byte_next = q_head.data[{idx_reg[1:0], 3'b000} +: 8];
                    err_next  = 1'b0;
                end
                default:
                begin
                    byte_next = 8'd0;
                    err_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule

/* sv/wav_pcm_stream_formatter_core.sv */
// the first byte of an item passes through its queue entry and then the output byte register before it shows
// throughput: one byte per cycle while m_tready is high; a sample is 1 to 4 bytes, an error 1, a header 44
// the output byte register sets the rate; a four-entry queue decouples input from output
// header fields come from two registered multiply stages fed by the configuration
// reset (rst_n low, asynchronous) empties the queue and output and loads default registers
module wav_pcm_stream_formatter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [31:0]                  s_tdata,   // [31:0] sample_value
    input  logic                                s_tuser,   // [0] req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast,   // last_byte
    output logic                                m_tuser,   // [0] depth_error
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    wps_pkg::desc_t q_desc;
    wps_pkg::desc_t q_head;
    wps_pkg::cfg_t  cfg;

    // accept and classify
    wps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_desc),
        .cfg       (cfg)
    );

    // item queue
    wps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .desc_in    (q_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // byte serialiser
    wps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* sv/wps_checker.sv */
module wps_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic [3:0] open_reg;
    logic [3:0] open_next;

    // items taken whose last byte has not yet left
    always_comb
    begin
        open_next = open_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready && m_tlast))
        begin
            open_next = open_reg + 1'b1;
        end
        else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready && m_tlast))
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // an error result is a single zero byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'h00)))
        else $error("error item is not a single zero byte");

    // output only while some item is still open
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (open_reg != 4'd0))
        else $error("output byte with no open item");

    // stalled output holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output changed while stalled");

endmodule

bind wav_pcm_stream_formatter_core wps_sva u_wps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
